// ----- src/dad_pkg.sv -----
// ----------------------------------------------------------------------------
// dad_pkg
// Shared constants, types and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

    // field widths fixed by the stream format
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int NIGHTS_W = 10;
    localparam int CENT_W   = 7;

    // input transfer width, fields packed and padded to whole bytes
    localparam int S_DATA_W = ((DAY_W + MONTH_W + YEAR_W + NIGHTS_W + 7) / 8) * 8;

    // default clamp on the day count
    localparam int MAX_NIGHTS_DEF = 1023;

    // calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

    // month codes
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // year / 100 as (year * CENT_RECIP) >> CENT_SHIFT, exact below 43699
    localparam int CENT_RECIP = 5243;
    localparam int CENT_SHIFT = 19;
    localparam int CENT_PROD_W = YEAR_W + 13;
    localparam logic [CENT_W-1:0] YEARS_PER_CENT = 7'd100;
    localparam logic [CENT_W-1:0] REM_LAST       = 7'd99;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture a new start date
        logic split;     // derive year mod 100
        logic step;      // cross one month end if the day overruns it
        logic out_load;  // move the finished date into the output register
    } dad_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fits;      // day lies inside the current month
        logic ovf_hit;   // next month end would run past the last year
        logic out_free;  // output register can take a new date this cycle
    } dad_status_t;

    // length of a month, given whether the year is a leap year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MON_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

// ----- src/dad_ctrl.sv -----
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer for the date adder: load, split the year, step months, hand off.
// ----------------------------------------------------------------------------
module dad_ctrl
    import dad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  dad_status_t status,
    output dad_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SPLIT = 4'b0010,
        ST_STEP  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (status.fits || status.ovf_hit) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/dad_datapath.sv -----
// ----------------------------------------------------------------------------
// dad_datapath
// Working date registers, month-length logic and the output register.
// ----------------------------------------------------------------------------
module dad_datapath
    import dad_pkg::*;
#(
    parameter int MAX_NIGHTS = MAX_NIGHTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [DAY_W-1:0]    start_day,
    input  logic [MONTH_W-1:0]  start_month,
    input  logic [YEAR_W-1:0]   start_year,
    input  logic [NIGHTS_W-1:0] nights,
    input  dad_cmd_t            cmd,
    output dad_status_t         status,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [DAY_W-1:0]    end_day,
    output logic [MONTH_W-1:0]  end_month,
    output logic [YEAR_W-1:0]   end_year,
    output logic                year_overflow
);

    localparam int ACC_W = $clog2(MAX_NIGHTS + 32);
    localparam int CMP_W = (ACC_W > NIGHTS_W) ? ACC_W : NIGHTS_W;

    logic [ACC_W-1:0]   day_reg,   day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [CENT_W-1:0]  cent_reg,  cent_next;
    logic [CENT_W-1:0]  rem_reg,   rem_next;
    logic               ovf_reg,   ovf_next;

    logic [DAY_W-1:0]   out_day_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [YEAR_W-1:0]  out_year_reg;
    logic               out_ovf_reg;
    logic               out_valid_reg, out_valid_next;

    logic [DAY_W-1:0]       d_clamp;
    logic [MONTH_W-1:0]     m_clamp;
    logic [YEAR_W-1:0]      y_clamp;
    logic [NIGHTS_W-1:0]    n_clamp;
    logic [CENT_PROD_W-1:0] cent_prod;
    logic [YEAR_W-1:0]      cent_years;
    logic                   leap;
    logic [DAY_W-1:0]       len;
    logic                   fits;
    logic                   ovf_hit;

    // clamp the start date and the day count into range
    always_comb begin
        d_clamp = (start_day == '0) ? DAY_MIN : start_day;
        m_clamp = start_month;
        if (start_month == '0) begin
            m_clamp = MON_JAN;
        end else if (start_month > MON_DEC) begin
            m_clamp = MON_DEC;
        end
        y_clamp = start_year;
        if (start_year == '0) begin
            y_clamp = YEAR_MIN;
        end else if (start_year > YEAR_MAX) begin
            y_clamp = YEAR_MAX;
        end
        n_clamp = (CMP_W'(nights) > CMP_W'(MAX_NIGHTS)) ? NIGHTS_W'(MAX_NIGHTS) : nights;
    end

    // century count by reciprocal multiply
    assign cent_prod  = CENT_PROD_W'(y_clamp) * CENT_PROD_W'(CENT_RECIP);
    assign cent_years = YEAR_W'(cent_reg) * YEAR_W'(YEARS_PER_CENT);

    // leap rule from year mod 4, year mod 100 and century mod 4
    assign leap = ((year_reg[1:0] == 2'b00) && (rem_reg != '0)) ||
                  ((rem_reg == '0) && (cent_reg[1:0] == 2'b00));

    assign len     = month_len(month_reg, leap);
    assign fits    = (day_reg <= ACC_W'(len));
    assign ovf_hit = !fits && (month_reg == MON_DEC) && (year_reg == YEAR_MAX);

    assign status.fits     = fits;
    assign status.ovf_hit  = ovf_hit;
    assign status.out_free = !out_valid_reg || m_tready;

    // working date update
    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        cent_next  = cent_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        if (cmd.load) begin
            day_next   = ACC_W'(d_clamp) + ACC_W'(n_clamp);
            month_next = m_clamp;
            year_next  = y_clamp;
            cent_next  = cent_prod[CENT_SHIFT +: CENT_W];
            ovf_next   = 1'b0;
        end else if (cmd.split) begin
            rem_next = CENT_W'(year_reg - cent_years);
        end else if (cmd.step && !fits) begin
            if (ovf_hit) begin
                ovf_next = 1'b1;
            end else begin
                day_next = day_reg - ACC_W'(len);
                if (month_reg == MON_DEC) begin
                    month_next = MON_JAN;
                    year_next  = year_reg + 1'b1;
                    if (rem_reg == REM_LAST) begin
                        rem_next  = '0;
                        cent_next = cent_reg + 1'b1;
                    end else begin
                        rem_next = rem_reg + 1'b1;
                    end
                end else begin
                    month_next = month_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        cent_reg  <= cent_next;
        rem_reg   <= rem_next;
        ovf_reg   <= ovf_next;
    end

    // output register, saturates on overflow
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_day_reg   <= ovf_reg ? DAY_LAST : DAY_W'(day_reg);
            out_month_reg <= ovf_reg ? MON_DEC  : month_reg;
            out_year_reg  <= ovf_reg ? YEAR_MAX : year_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // output valid, held until the transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign end_day       = out_day_reg;
    assign end_month     = out_month_reg;
    assign end_year      = out_year_reg;
    assign year_overflow = out_ovf_reg;

endmodule

// ----- src/date_add_days.sv -----
// ----------------------------------------------------------------------------
// date_add_days
// Gregorian date plus a number of days, on stream interfaces.
// ----------------------------------------------------------------------------
// One start date is taken at a time. Each item passes through these steps,
// where k is the number of month ends crossed (at most about 35 for 1023
// nights): the transfer loads the start date, the split state splits the year
// into centuries, the month-stepping loop crosses one month end per cycle, k
// times in all, plus a final check, and the flush state hands off once the
// output register is free. The month-stepping loop sets the time an item
// takes. The input is ready again while the result still waits in the output
// register. Dates past 31 December 9999 saturate with year_overflow.
// ----------------------------------------------------------------------------
module date_add_days
    import dad_pkg::*;
#(
    parameter int MAX_NIGHTS = MAX_NIGHTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_day, start_month, start_year, nights
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // end_day, end_month, end_year, year_overflow
    output logic [23:0]         m_tdata
);

    localparam int MON_LO    = DAY_W;
    localparam int YEAR_LO   = DAY_W + MONTH_W;
    localparam int NIGHTS_LO = DAY_W + MONTH_W + YEAR_W;

    dad_cmd_t           cmd;
    dad_status_t        status;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               year_overflow;

    // sequencer
    dad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // date registers and output stage
    dad_datapath #(
        .MAX_NIGHTS (MAX_NIGHTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_day     (s_tdata[0 +: DAY_W]),
        .start_month   (s_tdata[MON_LO +: MONTH_W]),
        .start_year    (s_tdata[YEAR_LO +: YEAR_W]),
        .nights        (s_tdata[NIGHTS_LO +: NIGHTS_W]),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .end_day       (end_day),
        .end_month     (end_month),
        .end_year      (end_year),
        .year_overflow (year_overflow)
    );

    // pack the result
    assign m_tdata = {year_overflow, end_year, end_month, end_day};

endmodule
